// ===== rtl/bounded_ordered_list_assert.svh =====
// Assertion macros used by the bounded ordered list controller.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef BOUNDED_ORDERED_LIST_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BOL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BOL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bol_pkg.sv =====
// Shared types, constants and helpers for the bounded ordered list.
// No dependencies; used by bol_cell, bol_ctrl and bounded_ordered_list.
package bol_pkg;

  localparam int CAPACITY    = 16;
  localparam int ITEM_BITS   = 32;
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int POS_W       = 4;
  localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int TUSER_W     = 3;

  typedef logic [ITEM_BITS-1:0] item_t;
  typedef logic [CNT_W-1:0]     count_t;

  typedef enum logic [2:0] {
    OP_INS_FIRST = 3'd0,
    OP_INS_LAST  = 3'd1,
    OP_DEL_VALUE = 3'd2,
    OP_DEL_INDEX = 3'd3,
    OP_DUMP      = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CK_NOP,
    CK_PUSH,
    CK_APPEND,
    CK_DEL_VAL,
    CK_DEL_POS,
    CK_ROTATE
  } cell_kind_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    cell_kind_t       kind;
    item_t            val;
    count_t           count;
    logic [POS_W-1:0] position;
  } cell_cmd_t;

  // Input word -> stored item: low ITEM_BITS bits, zero above bit 31.
  function automatic item_t to_item(input logic [31:0] d);
    logic [63:0] w;
    item_t       r;
    w = {32'b0, d};
    for (int i = 0; i < ITEM_BITS; i++) r[i] = w[i];
    return r;
  endfunction

  // Stored item -> 32-bit output, sign-extended from ITEM_BITS.
  function automatic logic [31:0] from_item(input item_t v);
    logic [63:0] w;
    logic [31:0] o;
    w = 64'(v);
    for (int i = 0; i < 32; i++) o[i] = (i < ITEM_BITS) ? w[i] : v[ITEM_BITS-1];
    return o;
  endfunction

  // Count -> 5-bit length field.
  function automatic logic [4:0] to_len(input count_t c);
    logic [63:0] w;
    w = 64'(c);
    return w[4:0];
  endfunction

endpackage

// ===== rtl/bol_cell.sv =====
// One list slot of the bounded ordered list cell row.
// Depends on bol_pkg; instantiated in a chain by bounded_ordered_list.
module bol_cell
  import bol_pkg::*;
(
  input  logic             clk,
  input  cell_cmd_t        cmd,
  input  logic [IDX_W-1:0] index,     // fixed slot number
  input  item_t            left,      // neighbor toward the front (data for slot 0)
  input  item_t            right,     // neighbor toward the back (zero for the last slot)
  input  item_t            head,      // slot 0, for rotation during dump
  input  logic             match_in,  // some earlier slot matched
  output logic             match_out,
  output item_t            value
);

  item_t  value_next;
  count_t idx_c;
  logic   occupied;
  logic   hit;
  logic   pos_ok;
  logic   past_pos;

  assign idx_c     = CNT_W'(index);
  assign occupied  = idx_c < cmd.count;
  assign hit       = occupied && (value == cmd.val);
  assign match_out = match_in | hit;
  assign pos_ok    = CMP_W'(cmd.position) < CMP_W'(cmd.count);
  assign past_pos  = CMP_W'(index) >= CMP_W'(cmd.position);

  always_comb begin
    value_next = value;
    case (cmd.kind)
      CK_PUSH:    value_next = left;
      CK_APPEND:  if (idx_c == cmd.count) value_next = cmd.val;
      CK_DEL_VAL: if (match_out) value_next = right;
      CK_DEL_POS: if (pos_ok && past_pos) value_next = right;
      CK_ROTATE: begin
        if (idx_c + 1'b1 < cmd.count) value_next = right;
        else if (idx_c + 1'b1 == cmd.count) value_next = head;
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ===== rtl/bol_ctrl.sv =====
// Controller of the bounded ordered list: op decode, count, dump sequencer,
// result register. Depends on bol_pkg and bounded_ordered_list_assert.svh.
module bol_ctrl
  import bol_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [TUSER_W-1:0]     s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast,
  input  item_t                  head,
  input  logic                   found,
  output cell_cmd_t              cmd
);

  `include "bounded_ordered_list_assert.svh"

  state_t      state, state_next;
  count_t      count, count_next;
  count_t      remaining, remaining_next;
  logic        out_valid;
  logic [31:0] out_item;
  logic        out_last;
  status_t     out_status;
  logic [4:0]  out_length;

  logic        accept;
  logic        out_free;
  logic        emit;
  logic [31:0] emit_item;
  logic        emit_last;
  status_t     emit_status;
  logic        full;
  logic        empty;
  logic        pos_valid;
  op_t         op;
  logic [POS_W-1:0] position;
  cell_kind_t  cmd_kind;
  logic        ins_taken;
  logic        remaining_ok;

  assign out_free  = !out_valid || m_tready;
  assign s_tready  = (state == S_IDLE) && out_free;
  assign accept    = s_tvalid && s_tready;
  assign op        = op_t'(s_tuser);
  assign position  = s_tdata[35:32];
  assign full      = count == count_t'(CAPACITY);
  assign empty     = count == '0;
  assign pos_valid = CMP_W'(position) < CMP_W'(count);

  // Cell command decode; kept apart from the found flag that the row returns.
  always_comb begin
    cmd_kind = CK_NOP;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_INS_FIRST: if (!full) cmd_kind = CK_PUSH;
            OP_INS_LAST:  if (!full) cmd_kind = CK_APPEND;
            OP_DEL_VALUE: if (!empty) cmd_kind = CK_DEL_VAL;
            OP_DEL_INDEX: if (pos_valid) cmd_kind = CK_DEL_POS;
            default: ;
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) cmd_kind = CK_ROTATE;
      end
      default: cmd_kind = CK_NOP;
    endcase
  end

  assign cmd = '{kind: cmd_kind, val: to_item(s_tdata[31:0]), count: count,
                 position: position};

  always_comb begin
    state_next     = state;
    count_next     = count;
    remaining_next = remaining;
    emit           = 1'b0;
    emit_item      = '0;
    emit_last      = 1'b1;
    emit_status    = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op) inside
            OP_INS_FIRST, OP_INS_LAST: begin
              emit = 1'b1;
              if (full) begin
                emit_status = ST_FULL;
              end else begin
                count_next = count + 1'b1;
              end
            end
            OP_DEL_VALUE: begin
              emit = 1'b1;
              if (empty) begin
                emit_status = ST_EMPTY;
              end else begin
                if (found) count_next = count - 1'b1;
                else emit_status = ST_NOT_FOUND;
              end
            end
            OP_DEL_INDEX: begin
              emit = 1'b1;
              if (empty) begin
                emit_status = ST_EMPTY;
              end else if (pos_valid) begin
                count_next = count - 1'b1;
              end else begin
                emit_status = ST_NOT_FOUND;
              end
            end
            OP_DUMP: begin
              if (empty) begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
              end else begin
                state_next     = S_DUMP;
                remaining_next = count;
              end
            end
            default: ;  // unused codes: no result, no change
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_item      = from_item(head);
          emit_last      = remaining == count_t'(1);
          remaining_next = remaining - 1'b1;
          if (remaining == count_t'(1)) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remaining <= remaining_next;
      if (emit) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item   <= emit_item;
      out_last   <= emit_last;
      out_status <= emit_status;
      out_length <= to_len(count_next);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {1'b0, out_length, out_status, out_item};

  assign ins_taken    = accept && !full && (op == OP_INS_FIRST || op == OP_INS_LAST);
  assign remaining_ok = (remaining != '0) && (remaining <= count);

  `BOL_ASSERT_NOW(a_count_bound, 1'b1, count <= count_t'(CAPACITY), "count above capacity")
  `BOL_ASSERT_NOW(a_dump_blocks, state == S_DUMP, !s_tready, "input taken during dump")
  `BOL_ASSERT_NOW(a_dump_remaining, state == S_DUMP, remaining_ok, "dump counter out of range")
  `BOL_ASSERT_NEXT(a_insert_grows, ins_taken, count == $past(count) + 1'b1, "insert did not grow")

endmodule

// ===== rtl/bounded_ordered_list.sv =====
// Top level of the bounded ordered list: controller plus a row of bol_cell.
// Depends on bol_pkg, bol_cell and bol_ctrl.
//
//  Channel | Signals                          | Direction | Carries
//  --------+----------------------------------+-----------+--------------------------------
//  s_      | s_tvalid s_tready s_tdata s_tuser | in        | one op transaction
//  m_      | m_tvalid m_tready m_tdata m_tlast | out       | one result transaction
//
// Insert, delete_value and delete_index are taken back to back while m_ is free; every
// cell compares and shifts at once and the result shows in the cycle after it is taken.
// Dump of n items: once it is taken, s_tready stays low while the row rotates by one
// slot and slot 0 is sent out each cycle, n times over, so the order stays intact.
// A stalled m_ side holds the result register, s_tready and the rotation. Reset
// clears count and control state; cells stay undefined, never read past the count.
module bounded_ordered_list
  import bol_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // data[31:0], position[35:32], zero pad
  input  logic [TUSER_W-1:0]     s_tuser,   // op[2:0]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // item[31:0], status[33:32], length[38:34], pad
  output logic                   m_tlast    // last
);

  cell_cmd_t cmd;
  item_t     value [CAPACITY];
  item_t     left  [CAPACITY];
  item_t     right [CAPACITY];
  logic      match [CAPACITY+1];

  // Match flag enters the front of the row clear; the tail tells whether
  // delete_value found its item.
  assign match[0] = 1'b0;

  bol_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .head     (value[0]),
    .found    (match[CAPACITY]),
    .cmd      (cmd)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    // Neighbor wiring: the front takes new data, the back pulls in zero.
    if (i == 0) begin : g_front
      assign left[i] = cmd.val;
    end else begin : g_mid_l
      assign left[i] = value[i-1];
    end
    if (i == CAPACITY - 1) begin : g_back
      assign right[i] = '0;
    end else begin : g_mid_r
      assign right[i] = value[i+1];
    end

    bol_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .index     (IDX_W'(i)),
      .left      (left[i]),
      .right     (right[i]),
      .head      (value[0]),
      .match_in  (match[i]),
      .match_out (match[i+1]),
      .value     (value[i])
    );
  end

endmodule
